@@ sv/sipq_pkg.sv @@
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; used by the cell and the top level.
package sipq_pkg;

    localparam int TAG_W    = 16;
    localparam int SCORE_W  = 16;
    localparam int OCC_W    = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [TAG_W-1:0] tag;
    } t_cell_cmd;

endpackage

@@ sv/sipq_cell.sv @@
// One slot of the sorted row: holds a score, a tag and a valid bit.
// Depends on sipq_pkg; instantiated in a chain by the top level.
module sipq_cell #(
    parameter int SCORE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sipq_pkg::t_cell_cmd          i_cmd,
    input  logic signed [SCORE_BITS-1:0] i_new_score,
    input  logic                         i_prev_go,
    input  logic                         i_prev_valid,
    input  logic signed [SCORE_BITS-1:0] i_prev_score,
    input  logic [sipq_pkg::TAG_W-1:0]   i_prev_tag,
    input  logic                         i_next_valid,
    input  logic signed [SCORE_BITS-1:0] i_next_score,
    input  logic [sipq_pkg::TAG_W-1:0]   i_next_tag,
    output logic                         o_go,
    output logic                         o_valid,
    output logic signed [SCORE_BITS-1:0] o_score,
    output logic [sipq_pkg::TAG_W-1:0]   o_tag
);
    import sipq_pkg::*;

    logic                         r_valid;
    logic signed [SCORE_BITS-1:0] r_score;
    logic [TAG_W-1:0]             r_tag;
    logic                         n_valid;
    logic signed [SCORE_BITS-1:0] n_score;
    logic [TAG_W-1:0]             n_tag;

    // Row is kept in descending order; the new entry lands in the first
    // slot that is empty or holds a strictly smaller score
    assign o_go = !r_valid || (r_score < i_new_score);

    always_comb begin
        n_valid = r_valid;
        n_score = r_score;
        n_tag   = r_tag;
        if (i_cmd.push && o_go) begin
            if (i_prev_go) begin
                n_valid = i_prev_valid;
                n_score = i_prev_score;
                n_tag   = i_prev_tag;
            end else begin
                n_valid = 1'b1;
                n_score = i_new_score;
                n_tag   = i_cmd.tag;
            end
        end else if (i_cmd.pop) begin
            // advance towards the head
            n_valid = i_next_valid;
            n_score = i_next_score;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_score <= n_score;
        r_tag   <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_score = r_score;
    assign o_tag   = r_tag;

endmodule

@@ sv/sorted_insert_priority_queue_unit.sv @@
// Top level of the sorted-insert priority queue: a chain of sipq_cell slots
// with an output register. Depends on sipq_pkg and sipq_cell.
//
// Usage:
//   Input channel s_axis: tuser is the kind (0 push, 1 pop), tdata carries
//   the score and the tag. Every transfer produces exactly one result.
//   Output channel m_axis: tuser carries the flags got_entry, was_empty and
//   push_rejected; tdata carries the popped score and tag (zero otherwise)
//   and the occupancy after the item.
//   The entries sit in a row of CAPACITY cells in descending score order,
//   the highest (and, among equals, oldest) at the head. Each cycle every
//   cell compares the pushed score with its own and shifts or holds, so a
//   push or pop needs no search of the row whatever the fill level.
//   The result is registered, valid in the cycle after the input transfer;
//   throughput is one item per cycle while the receiver takes results.
//   The result register forms the only buffer: when m_axis_tready is low
//   and a result is waiting, s_axis_tready drops until it is taken.
//   Reset (synchronous, active low) empties the queue at once and drops any
//   pending result; no clearing pass is needed.
module sorted_insert_priority_queue_unit #(
    parameter int CAPACITY   = 64,
    parameter int SCORE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] score, [31:16] tag
    input  logic [sipq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [0] kind
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [15:0] out_score, [31:16] out_tag, [38:32] occupancy, [39] zero
    output logic [sipq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] got_entry, [1] was_empty, [2] push_rejected
    output logic [sipq_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
    import sipq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                         in_xfer;
    logic                         is_pop;
    logic                         full;
    logic                         empty;
    logic signed [SCORE_BITS-1:0] new_score;
    t_cell_cmd                    cmd;

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic [OUT_TDATA_W-1:0]       r_out_tdata;
    logic [OUT_TUSER_W-1:0]       r_out_tuser;
    logic [OUT_TDATA_W-1:0]       n_out_tdata;
    logic [OUT_TUSER_W-1:0]       n_out_tuser;

    logic                         cell_go    [CAPACITY];
    logic                         cell_valid [CAPACITY];
    logic signed [SCORE_BITS-1:0] cell_score [CAPACITY];
    logic [TAG_W-1:0]             cell_tag   [CAPACITY];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (s_axis_tuser == KIND_POP);
    assign full          = (r_count == CNT_W'(CAPACITY));
    assign empty         = (r_count == '0);
    // wrap the 16-bit score to the stored width, keeping its sign
    assign new_score     = SCORE_BITS'($signed(s_axis_tdata[SCORE_W-1:0]));

    assign cmd.push = in_xfer && !is_pop && !full;
    assign cmd.pop  = in_xfer && is_pop && !empty;
    assign cmd.tag  = s_axis_tdata[SCORE_W +: TAG_W];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                         prev_go;
        logic                         prev_valid;
        logic signed [SCORE_BITS-1:0] prev_score;
        logic [TAG_W-1:0]             prev_tag;
        logic                         next_valid;
        logic signed [SCORE_BITS-1:0] next_score;
        logic [TAG_W-1:0]             next_tag;

        if (g == 0) begin : g_head
            assign prev_go    = 1'b0;
            assign prev_valid = 1'b0;
            assign prev_score = '0;
            assign prev_tag   = '0;
        end else begin : g_body
            assign prev_go    = cell_go[g-1];
            assign prev_valid = cell_valid[g-1];
            assign prev_score = cell_score[g-1];
            assign prev_tag   = cell_tag[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_score = '0;
            assign next_tag   = '0;
        end else begin : g_inner
            assign next_valid = cell_valid[g+1];
            assign next_score = cell_score[g+1];
            assign next_tag   = cell_tag[g+1];
        end

        sipq_cell #(
            .SCORE_BITS(SCORE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_new_score  (new_score),
            .i_prev_go    (prev_go),
            .i_prev_valid (prev_valid),
            .i_prev_score (prev_score),
            .i_prev_tag   (prev_tag),
            .i_next_valid (next_valid),
            .i_next_score (next_score),
            .i_next_tag   (next_tag),
            .o_go         (cell_go[g]),
            .o_valid      (cell_valid[g]),
            .o_score      (cell_score[g]),
            .o_tag        (cell_tag[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_tdata = '0;
        n_out_tuser = '0;
        if (cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        if (is_pop) begin
            if (empty) begin
                n_out_tuser[1] = 1'b1;
            end else begin
                n_out_tuser[0]                 = 1'b1;
                n_out_tdata[SCORE_W-1:0]       = SCORE_W'(cell_score[0]);
                n_out_tdata[SCORE_W +: TAG_W]  = cell_tag[0];
            end
        end else if (full) begin
            n_out_tuser[2] = 1'b1;
        end
        n_out_tdata[SCORE_W + TAG_W +: OCC_W] = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_xfer) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

endmodule
